// File: rtl/olt_pkg.sv
// Shared types and constants for the ordered list table engine.
// Used by olt_cell and ordered_list_table_engine; no dependencies.
package olt_pkg;

    // Fixed field widths of the request and result ports
    localparam int VALUE_W = 32;
    localparam int CMD_W   = 3;
    localparam int POS_W   = 9;
    localparam int STAT_W  = 3;
    localparam int FPOS_W  = 8;
    localparam int LEN_W   = 9;

    // Command codes carried by a request
    typedef enum logic [CMD_W-1:0] {
        CMD_GET        = 3'd0,
        CMD_REPLACE    = 3'd1,
        CMD_INSERT_AT  = 3'd2,
        CMD_DELETE_AT  = 3'd3,
        CMD_SET_INSERT = 3'd4,
        CMD_SET_FIND   = 3'd5,
        CMD_SET_REMOVE = 3'd6
    } t_cmd;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 3'd0,
        ST_BAD_INDEX = 3'd1,
        ST_FULL      = 3'd2,
        ST_PRESENT   = 3'd3,
        ST_NOT_FOUND = 3'd4
    } t_status;

    // Per-cycle action of every cell in the chain
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_DELETE = 2'd2,
        CELL_WRITE  = 2'd3
    } t_cell_op;

    // Control broadcast from the sequencer to all cells
    typedef struct packed {
        t_cell_op op;
        logic     capture;
    } t_cell_ctl;

    // Sequencer states
    typedef enum logic {
        S_IDLE  = 1'b0,
        S_APPLY = 1'b1
    } t_state;

endpackage

// File: rtl/ordered_list_table_engine.sv
// Top level of the ordered list table engine: sequencer, chain of cells and
// result register. Depends on olt_pkg, olt_cell and olt_first.
//
// Keeps an ordered list of up to CAPACITY elements, one per cell in a chain.
// For each request, at the accept edge every cell compares its element with
// the request value and stores the flags; at the apply edge the find-first
// pickers and position decode settle the result, all cells shift, write or
// hold in parallel, and the result is loaded into the output register. A new
// request is accepted only once the sequencer is back in idle after the apply
// step; the apply step waits only while the previous result is still
// stalled. After reset the list is empty and usable at once, with no
// clearing pass.
module ordered_list_table_engine #(
    parameter int CAPACITY   = 256,
    parameter int ELEM_WIDTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_req_valid,
    output logic                        o_req_stall,
    input  logic [olt_pkg::CMD_W-1:0]   i_cmd,
    input  logic [olt_pkg::POS_W-1:0]   i_position,
    input  logic [olt_pkg::VALUE_W-1:0] i_value,
    output logic                        o_rsp_valid,
    input  logic                        i_rsp_stall,
    output logic [olt_pkg::STAT_W-1:0]  o_status,
    output logic [olt_pkg::VALUE_W-1:0] o_value_out,
    output logic [olt_pkg::FPOS_W-1:0]  o_found_position,
    output logic [olt_pkg::LEN_W-1:0]   o_length
);
    import olt_pkg::*;

    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int IXW = $clog2(CAPACITY);
    localparam int PW  = (CW > POS_W) ? CW : POS_W;
    localparam int OW  = (ELEM_WIDTH < VALUE_W) ? ELEM_WIDTH : VALUE_W;

    // Sequencer and request registers
    t_state                r_state;
    t_state                n_state;
    t_cmd                  r_cmd;
    logic [POS_W-1:0]      r_pos;
    logic [ELEM_WIDTH-1:0] r_value;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic                  w_accept;
    logic                  w_apply;

    // Result register
    logic                  r_rsp_valid;
    t_status               r_status;
    logic [VALUE_W-1:0]    r_vout;
    logic [FPOS_W-1:0]     r_fpos;
    t_status               n_status;
    logic [VALUE_W-1:0]    n_vout;
    logic [FPOS_W-1:0]     n_fpos;

    // Cell chain signals
    t_cell_ctl             w_ctl;
    t_cell_op              w_op;
    logic [ELEM_WIDTH-1:0] w_in_elem;
    logic [ELEM_WIDTH-1:0] w_cell_value;
    logic [ELEM_WIDTH-1:0] w_entry [CAPACITY];
    logic [ELEM_WIDTH-1:0] w_left  [CAPACITY];
    logic [ELEM_WIDTH-1:0] w_right [CAPACITY];
    logic [CAPACITY-1:0]   w_ge;
    logic [CAPACITY-1:0]   w_eq;
    logic [CAPACITY-1:0]   w_at;
    logic [CAPACITY-1:0]   w_after;

    // Decode of positions and flags
    logic [CAPACITY-1:0]   w_live;
    logic [CAPACITY-1:0]   w_pos_hot;
    logic [CAPACITY-1:0]   w_pos_gt;
    logic [CAPACITY-1:0]   w_cnt_hot;
    logic [CAPACITY-1:0]   w_ge_live;
    logic [CAPACITY-1:0]   w_eq_live;
    logic [CAPACITY-1:0]   w_first_ge;
    logic [CAPACITY-1:0]   w_before_ge;
    logic                  w_any_ge;
    logic [CAPACITY-1:0]   w_first_eq;
    logic [CAPACITY-1:0]   w_before_eq;
    logic                  w_any_eq;
    logic [IXW-1:0]        w_lb_index;
    logic [ELEM_WIDTH-1:0] w_read;
    logic                  w_lb_match;
    logic                  w_pos_lt_cnt;
    logic                  w_pos_gt_cnt;
    logic                  w_full;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                if (!r_rsp_valid || !i_rsp_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_req_stall = 1'b1;
        w_accept    = 1'b0;
        w_apply     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_req_stall = 1'b0;
                w_accept    = i_req_valid;
            end
            S_APPLY: begin
                w_apply = !r_rsp_valid || !i_rsp_stall;
            end
            default: begin
                o_req_stall = 1'b1;
            end
        endcase
    end

    assign w_in_elem    = ELEM_WIDTH'(i_value[OW-1:0]);
    assign w_cell_value = (r_state == S_IDLE) ? w_in_elem : r_value;
    assign w_ctl.op      = w_apply ? w_op : CELL_HOLD;
    assign w_ctl.capture = w_accept;

    // Build the chain of cells with neighbor links
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign w_left[g] = r_value;
        end else begin : g_mid
            assign w_left[g] = w_entry[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_right[g] = w_entry[g];
        end else begin : g_inner
            assign w_right[g] = w_entry[g+1];
        end
        olt_cell #(
            .ELEM_WIDTH(ELEM_WIDTH)
        ) u_cell (
            .i_clk  (i_clk),
            .i_ctl  (w_ctl),
            .i_value(w_cell_value),
            .i_at   (w_at[g]),
            .i_after(w_after[g]),
            .i_left (w_left[g]),
            .i_right(w_right[g]),
            .o_entry(w_entry[g]),
            .o_ge   (w_ge[g]),
            .o_eq   (w_eq[g])
        );
    end

    // Decode cell index against position and count
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            w_live[i]    = PW'(i) <  PW'(r_count);
            w_cnt_hot[i] = PW'(i) == PW'(r_count);
            w_pos_hot[i] = PW'(i) == PW'(r_pos);
            w_pos_gt[i]  = PW'(i) >  PW'(r_pos);
        end
    end

    assign w_ge_live = w_ge & w_live;
    assign w_eq_live = w_eq & w_live;

    // Lower bound: first live element not below the value
    olt_first #(
        .N(CAPACITY)
    ) u_first_ge (
        .i_vec   (w_ge_live),
        .o_first (w_first_ge),
        .o_before(w_before_ge),
        .o_any   (w_any_ge)
    );

    // First live element equal to the value
    olt_first #(
        .N(CAPACITY)
    ) u_first_eq (
        .i_vec   (w_eq_live),
        .o_first (w_first_eq),
        .o_before(w_before_eq),
        .o_any   (w_any_eq)
    );

    // Encode the lower bound and read the addressed element
    always_comb begin
        w_lb_index = '0;
        w_read     = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (w_first_ge[i]) begin
                w_lb_index = w_lb_index | IXW'(i);
            end
            if (w_pos_hot[i]) begin
                w_read = w_read | w_entry[i];
            end
        end
    end

    assign w_lb_match   = |(w_first_ge & w_eq_live);
    assign w_pos_lt_cnt = PW'(r_pos) < PW'(r_count);
    assign w_pos_gt_cnt = PW'(r_pos) > PW'(r_count);
    assign w_full       = r_count == CW'(CAPACITY);

    // Decide status, result and the chain operation
    always_comb begin
        n_status = ST_OK;
        n_vout   = '0;
        n_fpos   = '0;
        n_count  = r_count;
        w_op     = CELL_HOLD;
        w_at     = w_pos_hot;
        w_after  = w_pos_gt;
        unique case (r_cmd)
            CMD_GET: begin
                if (w_pos_lt_cnt) begin
                    n_vout = VALUE_W'(w_read[OW-1:0]);
                end else begin
                    n_status = ST_BAD_INDEX;
                end
            end
            CMD_REPLACE: begin
                if (w_pos_lt_cnt) begin
                    n_vout = VALUE_W'(w_read[OW-1:0]);
                    w_op   = CELL_WRITE;
                end else begin
                    n_status = ST_BAD_INDEX;
                end
            end
            CMD_INSERT_AT: begin
                if (w_pos_gt_cnt) begin
                    n_status = ST_BAD_INDEX;
                end else if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_op    = CELL_INSERT;
                    n_count = r_count + CW'(1);
                end
            end
            CMD_DELETE_AT: begin
                if (w_pos_lt_cnt) begin
                    w_op    = CELL_DELETE;
                    n_count = r_count - CW'(1);
                end
            end
            CMD_SET_INSERT: begin
                w_at    = w_any_ge ? w_first_ge : w_cnt_hot;
                w_after = w_any_ge ? w_before_ge : (~w_live & ~w_cnt_hot);
                if (w_lb_match) begin
                    n_status = ST_PRESENT;
                end else if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_op    = CELL_INSERT;
                    n_count = r_count + CW'(1);
                end
            end
            CMD_SET_FIND: begin
                if (w_lb_match) begin
                    n_fpos = FPOS_W'(w_lb_index);
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            CMD_SET_REMOVE: begin
                w_at    = w_first_eq;
                w_after = w_before_eq;
                if (w_any_eq) begin
                    w_op    = CELL_DELETE;
                    n_count = r_count - CW'(1);
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_apply) begin
                r_count     <= n_count;
                r_rsp_valid <= 1'b1;
            end else if (!i_rsp_stall) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    // Hold the request and load the result
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd   <= t_cmd'(i_cmd);
            r_pos   <= i_position;
            r_value <= w_in_elem;
        end
        if (w_apply) begin
            r_status <= n_status;
            r_vout   <= n_vout;
            r_fpos   <= n_fpos;
        end
    end

    assign o_rsp_valid      = r_rsp_valid;
    assign o_status         = r_status;
    assign o_value_out      = r_vout;
    assign o_found_position = r_fpos;
    assign o_length         = LEN_W'(r_count);

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("element count exceeds capacity");

    a_count_only_on_apply: assert property (@(posedge i_clk)
        $past(i_rst_n) && !$past(w_apply) |-> $stable(r_count))
        else $error("element count changed outside an apply step");

    a_rsp_from_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_rsp_valid) |-> $past(r_state == S_APPLY))
        else $error("result appeared without an apply step");

    a_bad_index_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rsp_valid && (r_status == ST_BAD_INDEX) |-> (r_vout == '0))
        else $error("bad index result carries data");
`endif

endmodule

// File: rtl/olt_first.sv
// Find-first picker over a flag vector, built as a log-depth prefix OR.
// Depends on nothing; instanced by ordered_list_table_engine.
module olt_first #(
    parameter int N = 256
) (
    input  logic [N-1:0] i_vec,
    output logic [N-1:0] o_first,
    output logic [N-1:0] o_before,
    output logic         o_any
);

    logic [N-1:0] w_pre;

    // Inclusive prefix OR, doubling the span each step
    always_comb begin
        w_pre = i_vec;
        for (int s = 1; s < N; s = s * 2) begin
            w_pre = w_pre | (w_pre << s);
        end
    end

    // Lowest set flag and the mask of everything above it
    assign o_before = w_pre << 1;
    assign o_first  = i_vec & ~o_before;
    assign o_any    = w_pre[N-1];

endmodule

// File: rtl/olt_cell.sv
// One table cell: holds an element, compares it against the request value
// and shifts to or from its neighbors. Depends on olt_pkg.
module olt_cell #(
    parameter int ELEM_WIDTH = 32
) (
    input  logic                   i_clk,
    input  olt_pkg::t_cell_ctl     i_ctl,
    input  logic [ELEM_WIDTH-1:0]  i_value,
    input  logic                   i_at,
    input  logic                   i_after,
    input  logic [ELEM_WIDTH-1:0]  i_left,
    input  logic [ELEM_WIDTH-1:0]  i_right,
    output logic [ELEM_WIDTH-1:0]  o_entry,
    output logic                   o_ge,
    output logic                   o_eq
);
    import olt_pkg::*;

    logic [ELEM_WIDTH-1:0] r_entry;
    logic [ELEM_WIDTH-1:0] n_entry;
    logic                  r_ge;
    logic                  r_eq;

    // Select the next element from the broadcast operation
    always_comb begin
        n_entry = r_entry;
        unique case (i_ctl.op)
            CELL_HOLD: begin
                n_entry = r_entry;
            end
            CELL_INSERT: begin
                if (i_after) begin
                    n_entry = i_left;
                end else if (i_at) begin
                    n_entry = i_value;
                end
            end
            CELL_DELETE: begin
                if (i_after || i_at) begin
                    n_entry = i_right;
                end
            end
            CELL_WRITE: begin
                if (i_at) begin
                    n_entry = i_value;
                end
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    // Store the element and capture compare flags on request accept
    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        if (i_ctl.capture) begin
            r_ge <= (r_entry >= i_value);
            r_eq <= (r_entry == i_value);
        end
    end

    assign o_entry = r_entry;
    assign o_ge    = r_ge;
    assign o_eq    = r_eq;

endmodule
